/* sv/lzwd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzwd_pkg
// Types and constants for the LZSS window decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    localparam int unsigned WINDOW_SIZE = 4096;
    localparam int unsigned POS_W       = 12;
    localparam int unsigned CNT_W       = 40;
    localparam int unsigned BUF_W       = 24;
    localparam int unsigned BITS_W      = 5;
    localparam int unsigned LEN_W       = 5;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NO_END = 2'd1;
    localparam logic [1:0] STATUS_OVER   = 2'd2;
    localparam logic [1:0] STATUS_EMPTY  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MREAD,
        ST_EMIT,
        ST_MARK,
        ST_END,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             is_status;
        logic [1:0]       status_code;
        logic [CNT_W-1:0] decoded_count;
    } result_t;

endpackage : lzwd_pkg
`default_nettype wire

/* sv/lzss_window_decoder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lzss_window_decoder_unit
// LZSS decoder with a 4096-byte history ring and a per-stream output limit.
// ----------------------------------------------------------------------------
// One packed byte is taken per transfer while the sequencer is idle; the
// block is not ready again until every token completed by that byte has been
// decoded. Steps in order: take the byte, a token decode step per token
// (including a last one that finds too few bits), an emit step per literal,
// a registered ring read then a write and emit per byte copied from the
// history ring, a status step for the end marker, and the closing states
// ST_END and ST_FLUSH, plus any stalls on m_axis_tready. The over-limit
// status takes the slot of the byte it replaces and ends the decode; the
// missing end status is pushed in the first closing state, ST_END. A byte
// that arrives after the stream has finished is dropped while idle. The
// ring is not swept at stream start: entries not yet written in the current
// stream read as zero from the stream's byte count, so a new stream starts
// with no wait.
// ----------------------------------------------------------------------------
module lzss_window_decoder_unit
    import lzwd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wen,
    input  wire logic [CNT_W-1:0] cfg_wdata,      // output_limit
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,   // [7:0] packed_byte
    input  wire logic             s_axis_tlast,   // stream_end
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [55:0]           m_axis_tdata,   // [7:0] data_byte,
                                                  // [9:8] status_code,
                                                  // [49:10] decoded_count
    output logic                  m_axis_tuser,   // is_status
    output logic                  m_axis_tlast    // last_of_run
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    limit_reg;
    logic [BUF_W-1:0]    buf_reg, buf_next;
    logic [BITS_W-1:0]   cnt_reg, cnt_next;
    logic [POS_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic                finished_reg, finished_next;
    logic                last_reg, last_next;
    logic [7:0]          lit_reg, lit_next;
    logic                from_match_reg, from_match_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [7:0]          rdata_reg;
    logic [POS_W-1:0]    rd_addr;
    logic                ring_we;
    logic [7:0]          ring_wdata;
    logic [7:0]          ring_mem [WINDOW_SIZE];

    result_t             pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    result_t             out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_last_reg, out_last_next;

    result_t             push_res;
    logic                push_en;
    logic                push_ok;
    logic                m_free;
    logic                s_fire;
    logic                over;
    logic                flag_bit;
    logic [POS_W-1:0]    tok_pos;
    logic [LEN_W-1:0]    idx_inc;
    logic [BUF_W-1:0]    in_shifted;

    assign m_free     = !out_valid_reg || m_axis_tready;
    assign push_ok    = !pend_valid_reg || m_free;
    assign s_fire     = s_axis_tvalid && s_axis_tready;
    assign over       = (total_reg >= limit_reg);
    assign flag_bit   = buf_reg[BUF_W-1];
    assign tok_pos    = buf_reg[22:11];
    assign idx_inc    = idx_reg + LEN_W'(1);
    assign rd_addr    = pos_reg + POS_W'(idx_reg);
    assign in_shifted = {s_axis_tdata, 16'h0000} >> cnt_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_reg.decoded_count, out_reg.status_code,
                            out_reg.data_byte};
    assign m_axis_tuser  = out_reg.is_status;
    assign m_axis_tlast  = out_last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && !finished_reg)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_END;
                end
                else if (flag_bit)
                begin
                    state_next = (cnt_reg < BITS_W'(9)) ? ST_END : ST_EMIT;
                end
                else if (cnt_reg < BITS_W'(13))
                begin
                    state_next = ST_END;
                end
                else if (tok_pos == '0)
                begin
                    state_next = ST_MARK;
                end
                else
                begin
                    state_next = (cnt_reg < BITS_W'(17)) ? ST_END : ST_MREAD;
                end
            end
            ST_MREAD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (push_ok)
                begin
                    if (over)
                    begin
                        state_next = ST_END;
                    end
                    else if (from_match_reg && (idx_inc != len_reg))
                    begin
                        state_next = ST_MREAD;
                    end
                    else
                    begin
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_MARK:
            begin
                if (push_ok)
                begin
                    state_next = ST_END;
                end
            end
            ST_END:
            begin
                if (!last_reg || finished_reg || push_ok)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || m_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and result generation
    always_comb
    begin
        buf_next        = buf_reg;
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        total_next      = total_reg;
        finished_next   = finished_reg;
        last_next       = last_reg;
        lit_next        = lit_reg;
        from_match_next = from_match_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        rd_valid_next   = rd_valid_reg;
        ring_we         = 1'b0;
        ring_wdata      = lit_reg;
        push_en         = 1'b0;
        push_res        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    last_next = s_axis_tlast;
                    if (finished_reg)
                    begin
                        if (s_axis_tlast)
                        begin
                            ptr_next      = POS_W'(1);
                            buf_next      = '0;
                            cnt_next      = '0;
                            total_next    = '0;
                            finished_next = 1'b0;
                        end
                    end
                    else
                    begin
                        buf_next = buf_reg | in_shifted;
                        cnt_next = cnt_reg + BITS_W'(8);
                    end
                end
            end
            ST_DECODE:
            begin
                if (cnt_reg != '0)
                begin
                    if (flag_bit)
                    begin
                        if (cnt_reg >= BITS_W'(9))
                        begin
                            lit_next        = buf_reg[22:15];
                            from_match_next = 1'b0;
                            buf_next        = buf_reg << 9;
                            cnt_next        = cnt_reg - BITS_W'(9);
                        end
                    end
                    else if (cnt_reg >= BITS_W'(13))
                    begin
                        if (tok_pos == '0)
                        begin
                            buf_next = buf_reg << 13;
                            cnt_next = cnt_reg - BITS_W'(13);
                        end
                        else if (cnt_reg >= BITS_W'(17))
                        begin
                            pos_next        = tok_pos;
                            len_next        = {1'b0, buf_reg[10:7]} + LEN_W'(2);
                            idx_next        = '0;
                            from_match_next = 1'b1;
                            buf_next        = buf_reg << 17;
                            cnt_next        = cnt_reg - BITS_W'(17);
                        end
                    end
                end
            end
            ST_MREAD:
            begin
                rd_valid_next = (total_reg[CNT_W-1:POS_W] != '0)
                             || ((rd_addr != '0) && (rd_addr <= total_reg[POS_W-1:0]));
            end
            ST_EMIT:
            begin
                if (push_ok)
                begin
                    push_en = 1'b1;
                    if (over)
                    begin
                        push_res.is_status     = 1'b1;
                        push_res.status_code   = STATUS_OVER;
                        push_res.decoded_count = total_reg;
                        finished_next          = 1'b1;
                    end
                    else
                    begin
                        ring_wdata = from_match_reg ? (rd_valid_reg ? rdata_reg : 8'h00)
                                                    : lit_reg;
                        ring_we            = 1'b1;
                        ptr_next           = ptr_reg + POS_W'(1);
                        total_next         = total_reg + CNT_W'(1);
                        idx_next           = idx_inc;
                        push_res.data_byte = ring_wdata;
                    end
                end
            end
            ST_MARK:
            begin
                if (push_ok)
                begin
                    push_en                = 1'b1;
                    push_res.is_status     = 1'b1;
                    push_res.status_code   = (total_reg == '0) ? STATUS_EMPTY : STATUS_OK;
                    push_res.decoded_count = total_reg;
                    finished_next          = 1'b1;
                end
            end
            ST_END:
            begin
                if (last_reg && (finished_reg || push_ok))
                begin
                    if (!finished_reg)
                    begin
                        push_en                = 1'b1;
                        push_res.is_status     = 1'b1;
                        push_res.status_code   = STATUS_NO_END;
                        push_res.decoded_count = total_reg;
                    end
                    ptr_next      = POS_W'(1);
                    buf_next      = '0;
                    cnt_next      = '0;
                    total_next    = '0;
                    finished_next = 1'b0;
                end
            end
            ST_FLUSH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // one result is held back until it is known whether another follows it
    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        if (push_en)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_next       = push_res;
            pend_valid_next = 1'b1;
        end
        else if ((state_reg == ST_FLUSH) && pend_valid_reg && m_free)
        begin
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            limit_reg      <= '0;
            buf_reg        <= '0;
            cnt_reg        <= '0;
            ptr_reg        <= POS_W'(1);
            total_reg      <= '0;
            finished_reg   <= 1'b0;
            last_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wen)
            begin
                limit_reg <= cfg_wdata;
            end
            buf_reg        <= buf_next;
            cnt_reg        <= cnt_next;
            ptr_reg        <= ptr_next;
            total_reg      <= total_next;
            finished_reg   <= finished_next;
            last_reg       <= last_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg        <= lit_next;
        from_match_reg <= from_match_next;
        pos_reg        <= pos_next;
        len_reg        <= len_next;
        idx_reg        <= idx_next;
        rd_valid_reg   <= rd_valid_next;
        pend_reg       <= pend_next;
        out_reg        <= out_next;
        out_last_reg   <= out_last_next;
    end

    // history ring
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ptr_reg] <= ring_wdata;
        end
        rdata_reg <= ring_mem[rd_addr];
    end

endmodule : lzss_window_decoder_unit
`default_nettype wire
